// ===== rtl/abpg_pkg.sv =====
// abpg_pkg: shared types, command codes and palette functions of the pixel generator
// no dependencies
package abpg_pkg;

  localparam int OUT_WIDTH_DEF   = 320;
  localparam int OUT_HEIGHT_DEF  = 240;
  localparam int LEFT_BORDER_DEF = 32;
  localparam int TOP_BORDER_DEF  = 24;

  localparam int SCREEN_BYTES = 6912;
  localparam int ATTR_BASE    = 6144;
  localparam int PAPER_W      = 256;
  localparam int PAPER_H      = 192;
  localparam int SCREEN_AW    = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_SCREEN = 2'd0;
  localparam logic [1:0] CMD_BORDER = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;

  localparam logic [2:0] BORDER_WHITE = 3'd7;
  localparam logic [7:0] LVL_NORMAL   = 8'hD7;
  localparam logic [7:0] LVL_BRIGHT   = 8'hFF;

  typedef enum logic [1:0] {
    JOB_SCREEN,
    JOB_BORDER,
    JOB_RENDER
  } abpg_kind_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [SCREEN_AW-1:0] address;
    logic [7:0]           data;
    logic [7:0]           row;
    logic [5:0]           group;
    logic                 flash_phase;
  } abpg_req_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last;
  } abpg_res_t;

  typedef struct packed {
    abpg_kind_t           kind;
    logic [SCREEN_AW-1:0] address;
    logic [7:0]           data;
    logic [7:0]           row;
    logic [7:0]           py;
    logic                 row_in;
    logic [5:0]           group;
    logic [4:0]           col;
    logic                 flash_phase;
  } abpg_job_t;

  function automatic logic [15:0] abpg_rgb565(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // luminance 30/59/11 percent, truncated
  function automatic logic [7:0] abpg_grey(input logic [3:0] idx);
    logic [7:0] y;
    unique case (idx)
      4'd0:    y = 8'd0;
      4'd1:    y = 8'd23;
      4'd2:    y = 8'd64;
      4'd3:    y = 8'd88;
      4'd4:    y = 8'd126;
      4'd5:    y = 8'd150;
      4'd6:    y = 8'd191;
      4'd7:    y = 8'd215;
      4'd8:    y = 8'd0;
      4'd9:    y = 8'd28;
      4'd10:   y = 8'd76;
      4'd11:   y = 8'd104;
      4'd12:   y = 8'd150;
      4'd13:   y = 8'd178;
      4'd14:   y = 8'd226;
      default: y = 8'd255;
    endcase
    return y;
  endfunction

  function automatic logic [15:0] abpg_palette(input logic [3:0] idx, input logic colour);
    logic [7:0] lvl;
    logic [7:0] y;
    lvl = idx[3] ? LVL_BRIGHT : LVL_NORMAL;
    y   = abpg_grey(idx);
    if (colour) begin
      return abpg_rgb565(idx[1] ? lvl : 8'd0, idx[2] ? lvl : 8'd0, idx[0] ? lvl : 8'd0);
    end
    return abpg_rgb565(y, y, y);
  endfunction

endpackage

// ===== rtl/abpg_front.sv =====
// abpg_front: accepts items, drops those that do nothing and classifies the rest as jobs
// depends on abpg_pkg
module abpg_front import abpg_pkg::*; #(
  parameter int OUT_WIDTH   = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT  = OUT_HEIGHT_DEF,
  parameter int LEFT_BORDER = LEFT_BORDER_DEF,
  parameter int TOP_BORDER  = TOP_BORDER_DEF
) (
  input  logic      push,
  input  abpg_req_t request,
  input  logic      q_full,
  input  logic      init_busy,
  output logic      full,
  output abpg_job_t job,
  output logic      job_push
);

  localparam logic [9:0] WIDTH_L  = 10'(OUT_WIDTH);
  localparam logic [9:0] HEIGHT_L = 10'(OUT_HEIGHT);
  localparam logic [9:0] LEFT_L   = 10'(LEFT_BORDER);
  localparam logic [9:0] TOP_L    = 10'(TOP_BORDER);
  localparam logic [9:0] PAPER_HL = 10'(PAPER_H);

  logic       accept;
  logic       keep;
  logic [9:0] row_w;
  logic [9:0] x0;
  logic [9:0] rowd;
  logic [9:0] px0;

  assign full   = q_full || init_busy;
  assign accept = push && !full;

  assign row_w = {2'b00, request.row};
  assign x0    = {1'b0, request.group, 3'b000};
  assign rowd  = row_w - TOP_L;
  assign px0   = x0 - LEFT_L;

  always_comb begin
    job.address     = request.address;
    job.data        = request.data;
    job.row         = request.row;
    job.py          = rowd[7:0];
    job.row_in      = (row_w >= TOP_L) && (rowd < PAPER_HL);
    job.group       = request.group;
    job.col         = px0[7:3];
    job.flash_phase = request.flash_phase;
    job.kind        = JOB_RENDER;
    keep            = 1'b0;
    unique case (request.command)
      CMD_SCREEN: begin
        job.kind = JOB_SCREEN;
        keep     = request.address < SCREEN_AW'(SCREEN_BYTES);
      end
      CMD_BORDER: begin
        job.kind = JOB_BORDER;
        keep     = row_w < HEIGHT_L;
      end
      CMD_RENDER: begin
        job.kind = JOB_RENDER;
        keep     = (row_w < HEIGHT_L) && (x0 < WIDTH_L);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign job_push = accept && keep;

endmodule

// ===== rtl/abpg_queue.sv =====
// abpg_queue: short job queue between the front and the back
// depends on abpg_pkg
module abpg_queue import abpg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  abpg_job_t din,
  output logic      full,
  input  logic      pop,
  output abpg_job_t dout,
  output logic      empty
);

  abpg_job_t           slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/abpg_back.sv =====
// abpg_back: screen and border stores, render sequencer and result register
// depends on abpg_pkg
module abpg_back import abpg_pkg::*; #(
  parameter int OUT_WIDTH   = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT  = OUT_HEIGHT_DEF,
  parameter int LEFT_BORDER = LEFT_BORDER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      color_mode,
  input  logic      q_empty,
  input  abpg_job_t job,
  output logic      q_pop,
  output logic      init_busy,
  output logic      empty,
  input  logic      pop,
  output abpg_res_t result
);

  localparam int BORDER_DEPTH = (OUT_HEIGHT > 256) ? 256 : OUT_HEIGHT;
  localparam int BORDER_AW    = $clog2(BORDER_DEPTH);

  localparam logic [9:0] WIDTH_L   = 10'(OUT_WIDTH);
  localparam logic [9:0] LEFT_L    = 10'(LEFT_BORDER);
  localparam logic [9:0] PAPER_END = 10'(LEFT_BORDER + PAPER_W);

  localparam logic [SCREEN_AW-1:0] LAST_ADDR   = SCREEN_AW'(SCREEN_BYTES - 1);
  localparam logic [SCREEN_AW-1:0] BORDER_ROWS = SCREEN_AW'(BORDER_DEPTH);
  localparam logic [SCREEN_AW-1:0] ATTR_START  = SCREEN_AW'(ATTR_BASE);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t               state;
  logic [SCREEN_AW-1:0] clr;
  logic [2:0]           step;
  logic [2:0]           pcnt;
  abpg_job_t            cur;
  logic [7:0]           att0;
  logic [7:0]           pix0;
  logic [7:0]           att1;
  logic [7:0]           pix1;
  abpg_res_t            res;
  logic                 res_valid;

  logic [7:0]           screen_mem [SCREEN_BYTES];
  logic [2:0]           border_mem [BORDER_DEPTH];
  logic [7:0]           rdata;
  logic [2:0]           border_rd;

  logic                 scr_we;
  logic [SCREEN_AW-1:0] scr_waddr;
  logic [7:0]           scr_wdata;
  logic                 bdr_we;
  logic [BORDER_AW-1:0] bdr_waddr;
  logic [2:0]           bdr_wdata;
  logic [4:0]           rd_col;
  logic [SCREEN_AW-1:0] raddr;

  logic                 take;
  logic                 can_emit;
  logic [9:0]           x;
  logic [9:0]           px;
  logic                 in_paper;
  logic                 use_b;
  logic [7:0]           attr;
  logic [7:0]           bits;
  logic                 on;
  logic [3:0]           ink;
  logic [3:0]           pap;
  logic [3:0]           idx;
  logic [15:0]          pixel_val;

  assign init_busy = state == ST_INIT;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign take      = pop && res_valid;
  assign can_emit  = !res_valid || pop;
  assign empty     = !res_valid;
  assign result    = res;

  // write port: clearing pass, or a write job leaving the queue
  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = job.address;
    scr_wdata = job.data;
    bdr_we    = 1'b0;
    bdr_waddr = job.row[BORDER_AW-1:0];
    bdr_wdata = job.data[2:0];
    if (state == ST_INIT) begin
      scr_we    = 1'b1;
      scr_waddr = clr;
      scr_wdata = '0;
      bdr_we    = clr < BORDER_ROWS;
      bdr_waddr = clr[BORDER_AW-1:0];
      bdr_wdata = BORDER_WHITE;
    end else if (q_pop) begin
      scr_we = job.kind == JOB_SCREEN;
      bdr_we = job.kind == JOB_BORDER;
    end
  end

  // read order: attribute, bitmap for the first column, then the next column
  assign rd_col = step[1] ? cur.col + 5'd1 : cur.col;
  assign raddr  = step[0] ? {cur.py[7:6], cur.py[2:0], cur.py[5:3], rd_col}
                          : ATTR_START + {3'b000, cur.py[7:3], rd_col};

  always_ff @(posedge clk) begin
    if (scr_we) begin
      screen_mem[scr_waddr] <= scr_wdata;
    end
    rdata <= screen_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (bdr_we) begin
      border_mem[bdr_waddr] <= bdr_wdata;
    end
    border_rd <= border_mem[cur.row[BORDER_AW-1:0]];
  end

  // pixel decode
  always_comb begin
    x        = {1'b0, cur.group, pcnt};
    px       = x - LEFT_L;
    in_paper = cur.row_in && (x < WIDTH_L) && (x >= LEFT_L) && (x < PAPER_END);
    use_b    = px[7:3] != cur.col;
    attr     = use_b ? att1 : att0;
    bits     = use_b ? pix1 : pix0;
    on       = bits[~px[2:0]];
    ink      = {attr[6], attr[2:0]};
    pap      = {attr[6], attr[5:3]};
    if (attr[7] && cur.flash_phase) begin
      ink = {attr[6], attr[5:3]};
      pap = {attr[6], attr[2:0]};
    end
    if (in_paper) begin
      idx = on ? ink : pap;
    end else begin
      idx = {1'b0, border_rd};
    end
    pixel_val = abpg_palette(idx, color_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr       <= '0;
      step      <= '0;
      pcnt      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && can_emit) begin
        res_valid <= 1'b1;
      end else if (take) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          if (clr == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_pop && job.kind == JOB_RENDER) begin
            cur   <= job;
            step  <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          step <= step + 3'd1;
          case (step)
            3'd1:    att0 <= rdata;
            3'd2:    pix0 <= rdata;
            3'd3:    att1 <= rdata;
            3'd4:    pix1 <= rdata;
            default: ;
          endcase
          if (step == 3'd4) begin
            pcnt  <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            res  <= '{pixel: pixel_val, last: pcnt == 3'd7};
            pcnt <= pcnt + 3'd1;
            if (pcnt == 3'd7) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/attribute_bitmap_pixel_generator_unit.sv =====
// attribute_bitmap_pixel_generator_unit: top level of the attribute-bitmap pixel generator
// depends on abpg_pkg, abpg_front, abpg_queue, abpg_back
//
// After reset the block clears its 6912-byte screen store and sets every row border to white,
// one entry per cycle, and full stays high until that pass ends. Items then enter a four-entry
// job queue; the back end pops a job only while idle, and a write item is applied as it leaves
// the queue. A render item is dispatched, makes four reads (two attribute and two bitmap bytes)
// through the single read port of the screen store, and then delivers its eight pixels, one per
// cycle while pop keeps up. Items that do nothing are dropped at the input. Palette mode is
// written on the cfg channel, which is always ready, and should only change while no item is in flight.
module attribute_bitmap_pixel_generator_unit import abpg_pkg::*; #(
  parameter int OUT_WIDTH   = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT  = OUT_HEIGHT_DEF,
  parameter int LEFT_BORDER = LEFT_BORDER_DEF,
  parameter int TOP_BORDER  = TOP_BORDER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  abpg_req_t request,
  output logic      empty,
  input  logic      pop,
  output abpg_res_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      color_mode;
  logic      init_busy;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      job_push;
  abpg_job_t job_in;
  abpg_job_t job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      color_mode <= cfg_data;
    end
  end

  abpg_front #(
    .OUT_WIDTH   (OUT_WIDTH),
    .OUT_HEIGHT  (OUT_HEIGHT),
    .LEFT_BORDER (LEFT_BORDER),
    .TOP_BORDER  (TOP_BORDER)
  ) u_front (
    .push      (push),
    .request   (request),
    .q_full    (q_full),
    .init_busy (init_busy),
    .full      (full),
    .job       (job_in),
    .job_push  (job_push)
  );

  abpg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (job_out),
    .empty (q_empty)
  );

  abpg_back #(
    .OUT_WIDTH   (OUT_WIDTH),
    .OUT_HEIGHT  (OUT_HEIGHT),
    .LEFT_BORDER (LEFT_BORDER)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .color_mode (color_mode),
    .q_empty    (q_empty),
    .job        (job_out),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  // nothing queued and nothing delivered during the clearing pass
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (q_empty && empty))
    else $error("item queued or delivered during clearing pass");

  // pixels of one group follow each other without a gap
  a_group_flow: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=> !empty)
    else $error("gap inside a render group");

  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready) |=> $stable(color_mode))
    else $error("palette mode changed without a write");

endmodule
